>>> src/dltq_pkg.sv
// Shared constants and codes for the delta-list timer queue.
package dltq_pkg;

    localparam int DLTQ_CAPACITY = 64;
    localparam int DELTA_W       = 34;
    localparam int ID_W          = 32;
    localparam int DUR_W         = 32;
    localparam int ENTRY_W       = ID_W + DELTA_W;

    localparam logic [31:0] IDLE_WAIT_US = 32'd1000000;
    localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};

    // Operation codes carried in the input tuser.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Status codes carried in the output tuser.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

endpackage

>>> src/dltq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/delta_list_timer_queue_unit.sv
// Top level of the delta-list timer queue: sequencer, shared adder and entry RAM.
//
//  Channel | Direction | Handshake          | Payload
//  s       | in        | s_tvalid/s_tready  | s_tuser op, s_tdata {duration_us, seq_id}
//  m       | out       | m_tvalid/m_tready  | m_tuser status, m_tdata {next_wait_us, expired_id, expired}
//
// Each transaction is handled alone by a sequencer over one RAM port pair and one
// saturating 34-bit adder. Add scans the entries and then shifts those from the insert
// point on up; cancel scans to the match and shifts the later entries down; tick updates
// the head and, when it expires, shifts the rest down. Each then reads the head and
// forms the result. Reset empties the queue at once; RAM contents need no clearing.
// A result waits in the output register while the next transaction is accepted.
module delta_list_timer_queue_unit
    import dltq_pkg::*;
#(
    parameter int CAPACITY = DLTQ_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // seq_id [31:0], duration_us [63:32]
    input  logic [1:0]  s_tuser,   // op [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // expired [0], expired_id [32:1], next_wait_us [64:33], zero
    output logic [1:0]  m_tuser    // status [1:0]
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO     = CNT_W'(2);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_SCAN_RD  = 13'b0000000000010,
        S_SCAN_CHK = 13'b0000000000100,
        S_INS_RD   = 13'b0000000001000,
        S_INS_WR   = 13'b0000000010000,
        S_INS_PUT  = 13'b0000000100000,
        S_TICK_RD  = 13'b0000001000000,
        S_TICK_CHK = 13'b0000010000000,
        S_DROP_RD  = 13'b0000100000000,
        S_DROP_WR  = 13'b0001000000000,
        S_HEAD_RD  = 13'b0010000000000,
        S_HEAD_CHK = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic signed [DELTA_W-1:0] rem_reg, rem_next;
    logic signed [DELTA_W-1:0] carry_reg, carry_next;
    logic going_reg, going_next;
    logic [1:0] op_reg, op_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [DUR_W-1:0] dur_reg, dur_next;
    logic [1:0] status_reg, status_next;
    logic exp_reg, exp_next;
    logic [ID_W-1:0] exp_id_reg, exp_id_next;
    logic [31:0] wait_reg, wait_next;
    logic out_valid_reg, out_valid_next;
    logic [1:0] out_status_reg, out_status_next;
    logic out_exp_reg, out_exp_next;
    logic [ID_W-1:0] out_exp_id_reg, out_exp_id_next;
    logic [31:0] out_wait_reg, out_wait_next;

    // RAM ports.
    logic wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data;
    logic signed [DELTA_W-1:0] rd_delta;
    logic [ID_W-1:0] rd_id;

    // Shared saturating adder.
    logic signed [DELTA_W-1:0] alu_a, alu_b;
    logic alu_sub;
    logic signed [DELTA_W:0] alu_sum;
    logic signed [DELTA_W-1:0] alu_sat;
    logic alu_gt0;

    logic [CNT_W-1:0] idx_inc, idx_dec;
    logic [CNT_W-1:0] scan_pos;
    logic id_match;

    dltq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign rd_delta = rd_data[DELTA_W-1:0];
    assign rd_id    = rd_data[ENTRY_W-1:DELTA_W];
    assign idx_inc  = idx_reg + ONE;
    assign idx_dec  = idx_reg - ONE;
    assign id_match = (rd_id == id_reg);

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            S_SCAN_CHK:
            begin
                alu_a = rem_reg;
                alu_b = rd_delta;
            end
            S_TICK_CHK:
            begin
                alu_a = rd_delta;
                alu_b = {2'b00, dur_reg};
            end
            S_INS_WR:
            begin
                alu_a = rd_delta;
                alu_b = rem_reg;
            end
            S_DROP_WR:
            begin
                alu_a   = rd_delta;
                alu_b   = carry_reg;
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // Add or subtract at one extra bit, then clamp to the 34-bit range.
    always_comb
    begin
        if (alu_sub)
        begin
            alu_sum = {alu_a[DELTA_W-1], alu_a} - {alu_b[DELTA_W-1], alu_b};
        end
        else
        begin
            alu_sum = {alu_a[DELTA_W-1], alu_a} + {alu_b[DELTA_W-1], alu_b};
        end
        if (alu_sum[DELTA_W] != alu_sum[DELTA_W-1])
        begin
            alu_sat = alu_sum[DELTA_W] ? DELTA_MIN : DELTA_MAX;
        end
        else
        begin
            alu_sat = alu_sum[DELTA_W-1:0];
        end
        alu_gt0 = !alu_sum[DELTA_W] && (alu_sum != '0);
    end

    // Insert position after this scan step.
    assign scan_pos = (going_reg && alu_gt0) ? idx_inc : pos_reg;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        carry_next      = carry_reg;
        going_next      = going_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        dur_next        = dur_reg;
        status_next     = status_reg;
        exp_next        = exp_reg;
        exp_id_next     = exp_id_reg;
        wait_next       = wait_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_exp_next    = out_exp_reg;
        out_exp_id_next = out_exp_id_reg;
        out_wait_next   = out_wait_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[ADDR_W-1:0];
        wr_data         = rd_data;
        rd_addr         = idx_reg[ADDR_W-1:0];
        s_tready        = 1'b0;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next     = s_tuser;
                    id_next     = s_tdata[31:0];
                    dur_next    = s_tdata[63:32];
                    status_next = ST_OK;
                    exp_next    = 1'b0;
                    exp_id_next = '0;
                    idx_next    = '0;
                    pos_next    = '0;
                    rem_next    = {2'b00, s_tdata[63:32]};
                    going_next  = 1'b1;
                    case (s_tuser)
                        OP_ADD:
                        begin
                            state_next = (count_reg == '0) ? S_INS_PUT : S_SCAN_RD;
                        end
                        OP_CANCEL:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                                state_next  = S_HEAD_RD;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_TICK:
                        begin
                            state_next = (count_reg == '0) ? S_HEAD_RD : S_TICK_RD;
                        end
                        default:
                        begin
                            state_next = S_HEAD_RD;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            // Compare one entry: id search, and for add the running insert point.
            S_SCAN_CHK:
            begin
                if (op_reg == OP_ADD)
                begin
                    if (id_match)
                    begin
                        status_next = ST_DUPLICATE;
                        state_next  = S_HEAD_RD;
                    end
                    else
                    begin
                        if (going_reg && alu_gt0)
                        begin
                            rem_next = alu_sat;
                        end
                        else
                        begin
                            going_next = 1'b0;
                        end
                        pos_next = scan_pos;
                        if (idx_inc == count_reg)
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_HEAD_RD;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = (count_reg > scan_pos) ? S_INS_RD : S_INS_PUT;
                            end
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            state_next = S_SCAN_RD;
                        end
                    end
                end
                else
                begin
                    if (id_match)
                    begin
                        pos_next   = idx_reg;
                        carry_next = rd_delta;
                        if (idx_inc < count_reg)
                        begin
                            state_next = S_DROP_RD;
                        end
                        else
                        begin
                            count_next = count_reg - ONE;
                            state_next = S_HEAD_RD;
                        end
                    end
                    else if (idx_inc == count_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_HEAD_RD;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_SCAN_RD;
                    end
                end
            end

            // Move entry idx-1 up to idx; the old entry at the insert point loses rem.
            S_INS_RD:
            begin
                rd_addr    = idx_dec[ADDR_W-1:0];
                state_next = S_INS_WR;
            end

            S_INS_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[ADDR_W-1:0];
                wr_data  = {rd_id, (idx_dec == pos_reg) ? alu_sat : rd_delta};
                idx_next = idx_dec;
                state_next = (idx_dec > pos_reg) ? S_INS_RD : S_INS_PUT;
            end

            S_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[ADDR_W-1:0];
                wr_data    = {id_reg, rem_reg};
                count_next = count_reg + ONE;
                state_next = S_HEAD_RD;
            end

            S_TICK_RD:
            begin
                rd_addr    = '0;
                state_next = S_TICK_CHK;
            end

            // Charge elapsed time to the head; expire it when it drops to zero or below.
            S_TICK_CHK:
            begin
                if (alu_gt0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = {rd_id, alu_sat};
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    exp_next    = 1'b1;
                    exp_id_next = rd_id;
                    pos_next    = '0;
                    idx_next    = '0;
                    carry_next  = alu_sat;
                    if (count_reg > ONE)
                    begin
                        state_next = S_DROP_RD;
                    end
                    else
                    begin
                        count_next = count_reg - ONE;
                        state_next = S_HEAD_RD;
                    end
                end
            end

            // Move entry idx+1 down to idx; the successor of the dropped one gains carry.
            S_DROP_RD:
            begin
                rd_addr    = idx_inc[ADDR_W-1:0];
                state_next = S_DROP_WR;
            end

            S_DROP_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[ADDR_W-1:0];
                wr_data  = {rd_id, (idx_reg == pos_reg) ? alu_sat : rd_delta};
                idx_next = idx_inc;
                if ((idx_reg + TWO) < count_reg)
                begin
                    state_next = S_DROP_RD;
                end
                else
                begin
                    count_next = count_reg - ONE;
                    state_next = S_HEAD_RD;
                end
            end

            S_HEAD_RD:
            begin
                rd_addr    = '0;
                state_next = S_HEAD_CHK;
            end

            // Next wait from the head delta.
            S_HEAD_CHK:
            begin
                if ((count_reg == '0) || rd_delta[DELTA_W-1] || (rd_delta == '0))
                begin
                    wait_next = IDLE_WAIT_US;
                end
                else if (rd_delta[DELTA_W-2:32] != '0)
                begin
                    wait_next = 32'hFFFF_FFFF;
                end
                else
                begin
                    wait_next = rd_delta[31:0];
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_exp_next    = exp_reg;
                    out_exp_id_next = exp_id_reg;
                    out_wait_next   = wait_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        rem_reg        <= rem_next;
        carry_reg      <= carry_next;
        going_reg      <= going_next;
        op_reg         <= op_next;
        id_reg         <= id_next;
        dur_reg        <= dur_next;
        status_reg     <= status_next;
        exp_reg        <= exp_next;
        exp_id_reg     <= exp_id_next;
        wait_reg       <= wait_next;
        out_status_reg <= out_status_next;
        out_exp_reg    <= out_exp_next;
        out_exp_id_reg <= out_exp_id_next;
        out_wait_reg   <= out_wait_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'b0, out_wait_reg, out_exp_id_reg, out_exp_reg};

endmodule
